// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; included by the checker only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CLK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CLK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/clook_pkg.sv -----
// Shared types and codes for the C-LOOK request scheduler.
// No dependencies; used by the cell, the top level and the checker.
package clook_pkg;

    localparam int SECTOR_W = 48;
    localparam int COUNT_W  = 16;
    localparam int TAG_W    = 8;
    localparam int HEAD_W   = 49;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DISPATCHED = 3'd1;
    localparam logic [STATUS_W-1:0] STS_REMOVED    = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EMPTY      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL       = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [TAG_W-1:0]    request_tag;
        logic [SECTOR_W-1:0] start_sector;
        logic [COUNT_W-1:0]  sector_count;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic [SECTOR_W-1:0] out_sector;
        logic [COUNT_W-1:0]  out_count;
    } t_out_beat;

    // One pending request held in a cell
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic            capture;
        logic            commit;
        logic [OP_W-1:0] op;
        logic            wrap;
    } t_cell_ctrl;

endpackage

// ----- design/clook_cell.sv -----
// One slot of the sorted request row: holds an entry and a match flag.
// Depends on clook_pkg; instantiated in a row by the top level.
module clook_cell #(
    parameter int INDEX = 0,
    parameter int OCC_W = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clook_pkg::t_cell_ctrl         i_ctrl,
    input  logic [OCC_W-1:0]              i_occupancy,
    input  clook_pkg::t_in_beat           i_item,
    input  logic [clook_pkg::HEAD_W-1:0]  i_head,
    input  clook_pkg::t_entry             i_prev,
    input  clook_pkg::t_entry             i_next,
    input  logic                          i_found,
    output logic                          o_found,
    output logic                          o_first,
    output clook_pkg::t_entry             o_entry
);

    clook_pkg::t_entry r_entry, n_entry;
    logic              r_hit, n_hit;
    logic              occupied;

    assign occupied = OCC_W'(INDEX) < i_occupancy;

    // Compare phase: flag this slot against the incoming item
    always_comb begin
        case (i_ctrl.op)
            clook_pkg::OP_ADD:
                n_hit = !(occupied && (r_entry.sector < i_item.start_sector));
            clook_pkg::OP_DISPATCH:
                n_hit = occupied && !({1'b0, r_entry.sector} < i_head);
            clook_pkg::OP_REMOVE:
                n_hit = occupied && (r_entry.tag == i_item.request_tag);
            default:
                n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_hit <= n_hit;
        end
    end

    // Found chain: first flagged slot along the row
    assign o_first = r_hit && !i_found;
    assign o_found = i_found || r_hit;

    // Update phase: insert, shift up, or close the gap
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.commit) begin
            case (i_ctrl.op)
                clook_pkg::OP_ADD: begin
                    if (o_first) begin
                        n_entry.sector = i_item.start_sector;
                        n_entry.count  = i_item.sector_count;
                        n_entry.tag    = i_item.request_tag;
                    end else if (i_found) begin
                        n_entry = i_prev;
                    end
                end
                clook_pkg::OP_DISPATCH, clook_pkg::OP_REMOVE: begin
                    if (o_found || i_ctrl.wrap) begin
                        n_entry = i_next;
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- design/clook_request_scheduler_core.sv -----
// Channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_in_beat  (clook_pkg::t_in_beat)
// out     | output    | o_out_valid / i_out_stall | o_out_beat (clook_pkg::t_out_beat)
//
// Each add, dispatch or remove has a compare phase on accept, which flags the item in
// every cell of the row, and an update phase in S_EXEC, which walks the found chain
// and updates the row. An unused op is taken in S_IDLE alone and gives no beat.
// Reset clears occupancy and head; entries hold no reset value.
// A stalled output beat holds the update cycle until the register frees up.
// Top level of the C-LOOK request scheduler; depends on clook_pkg and clook_cell.
module clook_request_scheduler_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  clook_pkg::t_in_beat  i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output clook_pkg::t_out_beat o_out_beat
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                        r_state, n_state;
    clook_pkg::t_in_beat           r_item;
    logic [OCC_W-1:0]              r_occ, n_occ;
    logic [clook_pkg::HEAD_W-1:0]  r_head, n_head;
    logic                          r_out_valid;
    clook_pkg::t_out_beat          r_out_beat, n_out_beat;

    clook_pkg::t_in_beat           item_bus;
    clook_pkg::t_cell_ctrl         ctrl;
    clook_pkg::t_entry             cell_entry [QUEUE_DEPTH];
    clook_pkg::t_entry             prev_entry [QUEUE_DEPTH];
    clook_pkg::t_entry             next_entry [QUEUE_DEPTH];
    clook_pkg::t_entry             sel_entry;
    logic [QUEUE_DEPTH:0]          found_chain;
    logic [QUEUE_DEPTH-1:0]        first_vec;
    logic                          accept, out_free, exec_go, full, empty, wrap;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign exec_go  = (r_state == S_EXEC) && out_free;
    assign full     = r_occ == OCC_W'(QUEUE_DEPTH);
    assign empty    = r_occ == '0;
    assign item_bus = (r_state == S_IDLE) ? i_in_beat : r_item;

    // Dispatch with no entry at or above the head wraps to the lowest one
    assign wrap = (r_item.op == clook_pkg::OP_DISPATCH) && !empty
                  && !found_chain[QUEUE_DEPTH];

    // Cell control
    always_comb begin
        ctrl.capture = accept && (i_in_beat.op != clook_pkg::OP_NONE);
        ctrl.commit  = exec_go && !((r_item.op == clook_pkg::OP_ADD) && full);
        ctrl.op      = item_bus.op;
        ctrl.wrap    = wrap;
    end

    // Cell row
    assign found_chain[0] = 1'b0;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign prev_entry[gi] = cell_entry[gi];
        end else begin : g_mid
            assign prev_entry[gi] = cell_entry[gi-1];
        end
        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign next_entry[gi] = cell_entry[gi];
        end else begin : g_inner
            assign next_entry[gi] = cell_entry[gi+1];
        end

        clook_cell #(
            .INDEX (gi),
            .OCC_W (OCC_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_occupancy (r_occ),
            .i_item      (item_bus),
            .i_head      (r_head),
            .i_prev      (prev_entry[gi]),
            .i_next      (next_entry[gi]),
            .i_found     (found_chain[gi]),
            .o_found     (found_chain[gi+1]),
            .o_first     (first_vec[gi]),
            .o_entry     (cell_entry[gi])
        );
    end

    // One-hot pick of the dispatched entry
    always_comb begin
        sel_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (first_vec[i] || (wrap && (i == 0))) begin
                sel_entry = clook_pkg::t_entry'(sel_entry | cell_entry[i]);
            end
        end
    end

    // Result and bookkeeping for the update cycle
    always_comb begin
        n_out_beat = '0;
        n_occ      = r_occ;
        n_head     = r_head;
        case (r_item.op)
            clook_pkg::OP_ADD: begin
                if (full) begin
                    n_out_beat.status = clook_pkg::STS_FULL;
                end else begin
                    n_out_beat.status = clook_pkg::STS_ADDED;
                    n_occ             = r_occ + OCC_W'(1);
                end
            end
            clook_pkg::OP_DISPATCH: begin
                if (empty) begin
                    n_out_beat.status = clook_pkg::STS_EMPTY;
                end else begin
                    n_out_beat.status     = clook_pkg::STS_DISPATCHED;
                    n_out_beat.out_tag    = sel_entry.tag;
                    n_out_beat.out_sector = sel_entry.sector;
                    n_out_beat.out_count  = sel_entry.count;
                    n_head = {1'b0, sel_entry.sector}
                             + {{(clook_pkg::HEAD_W - clook_pkg::COUNT_W){1'b0}},
                                sel_entry.count};
                    n_occ  = r_occ - OCC_W'(1);
                end
            end
            clook_pkg::OP_REMOVE: begin
                if (found_chain[QUEUE_DEPTH]) begin
                    n_out_beat.status = clook_pkg::STS_REMOVED;
                    n_occ             = r_occ - OCC_W'(1);
                end else begin
                    n_out_beat.status = clook_pkg::STS_NOTFOUND;
                end
            end
            default: n_out_beat.status = clook_pkg::STS_NOTFOUND;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in_beat.op != clook_pkg::OP_NONE)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_occ       <= n_occ;
                r_head      <= n_head;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_beat;
        end
        if (exec_go) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- design/clook_checker.sv -----
// Port-level checker for the C-LOOK scheduler, bound to the top level.
// Depends on clook_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clook_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input clook_pkg::t_in_beat  i_in_beat,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input clook_pkg::t_out_beat o_out_beat
);

    // A stalled beat stays valid and unchanged
    `CLK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "out beat dropped under stall")
    `CLK_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_beat), "out beat changed under stall")

    // Status codes stay within the defined set
    `CLK_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_beat.status <= clook_pkg::STS_NOTFOUND, "bad status code")

    // Only a dispatch beat carries request fields
    `CLK_ASSERT_NOW(a_zero_fields, i_clk, i_rst_n, o_out_valid && (o_out_beat.status != clook_pkg::STS_DISPATCHED), (o_out_beat.out_tag == '0) && (o_out_beat.out_sector == '0) && (o_out_beat.out_count == '0), "nonzero fields on non-dispatch beat")

    // A real operation holds off the next beat for its update cycle
    `CLK_ASSERT_NEXT(a_busy_after_op, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_beat.op != clook_pkg::OP_NONE), o_in_stall, "input taken during update cycle")

endmodule

bind clook_request_scheduler_core clook_checker u_clook_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
